// ----- sv/mphd_pkg.sv -----
package mphd_pkg;

    localparam int WORD_BITS = 32;
    localparam int MAX_WORDS = 1024;

    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(MAX_WORDS);
    localparam int CNT_W  = $clog2(MAX_WORDS + 1);
    localparam int DIST_W = 6;

    localparam logic [DATA_W-1:0] WORD_MASK =
        (WORD_BITS >= DATA_W) ? {DATA_W{1'b1}} : DATA_W'((64'd1 << WORD_BITS) - 64'd1);

    localparam logic [DIST_W-1:0] START_MIN =
        (WORD_BITS > 63) ? DIST_W'(63) : DIST_W'(WORD_BITS);

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_WORDS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } wr_req_t;

    // Population count as an adder tree: nibbles, then bytes, halves and the whole word.
    function automatic logic [DIST_W-1:0] popcount32(input logic [DATA_W-1:0] x);
        logic [2:0] nib [8];
        logic [3:0] byt [4];
        logic [4:0] half [2];
        for (int n = 0; n < 8; n++) begin
            nib[n] = {2'b00, x[4*n]} + {2'b00, x[4*n+1]}
                   + {2'b00, x[4*n+2]} + {2'b00, x[4*n+3]};
        end
        for (int n = 0; n < 4; n++) begin
            byt[n] = {1'b0, nib[2*n]} + {1'b0, nib[2*n+1]};
        end
        for (int n = 0; n < 2; n++) begin
            half[n] = {1'b0, byt[2*n]} + {1'b0, byt[2*n+1]};
        end
        return {1'b0, half[0]} + {1'b0, half[1]};
    endfunction

endpackage

// ----- sv/min_pairwise_hamming_distance.sv -----
// Channel   Direction  Ports                              Contents
// s_        in         s_tvalid s_tready s_tdata s_tlast  one code word, last flag ends the set
// m_        out        m_tvalid m_tready m_tdata          minimum distance and overflow flag
//
// An item whose set already holds N stored words is accepted; then the N stored
// words are read from the word memory (one read port, one word per cycle); then
// the last comparison finishes; then the word is stored and the set closed. The
// first word of a set, and a word beyond the memory's capacity, go straight to
// the closing step. The next item is accepted only when the block is idle.
// The result sits in an output register; a stalled result holds the block in
// its closing step but never loses an item. Reset (aresetn low, synchronous)
// clears the count, the running minimum and the overflow flag; the memory
// needs no clearing since only entries written in the current set are read.
module min_pairwise_hamming_distance (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] word
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [5:0] min_distance, [6] overflow, [7] zero
);
    import mphd_pkg::*;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [DIST_W-1:0]   min_reg, min_next;
    logic                ovf_reg, ovf_next;
    logic [DATA_W-1:0]   word_reg, word_next;
    logic                last_reg, last_next;
    logic                store_reg, store_next;
    logic                cmp_valid_reg;
    logic                m_valid_reg, m_valid_next;
    logic [DIST_W-1:0]   m_min_reg, m_min_next;
    logic                m_ovf_reg, m_ovf_next;

    logic                s_accept;
    logic                out_free;
    logic                rd_en;
    logic [DATA_W-1:0]   rd_data;
    logic [DIST_W-1:0]   pair_dist;
    wr_req_t             wr;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign rd_en     = (state_reg == ST_SCAN);
    assign pair_dist = popcount32(word_reg ^ rd_data);

    assign wr.en   = (state_reg == ST_FINISH) && store_reg;
    assign wr.addr = count_reg[ADDR_W-1:0];
    assign wr.data = word_reg;

    mphd_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if ((count_reg < MAX_COUNT) && (count_reg != '0)) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_idx_reg + CNT_W'(1) == count_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!last_reg || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        count_next   = count_reg;
        rd_idx_next  = rd_idx_reg;
        min_next     = min_reg;
        ovf_next     = ovf_reg;
        word_next    = word_reg;
        last_next    = last_reg;
        store_next   = store_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_min_next   = m_min_reg;
        m_ovf_next   = m_ovf_reg;

        // Read data arrives in the cycle after its address.
        if (cmp_valid_reg && (pair_dist < min_reg)) begin
            min_next = pair_dist;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    word_next   = s_tdata & WORD_MASK;
                    last_next   = s_tlast;
                    store_next  = (count_reg < MAX_COUNT);
                    rd_idx_next = '0;
                    if (count_reg >= MAX_COUNT) begin
                        ovf_next = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                rd_idx_next = rd_idx_reg + CNT_W'(1);
            end
            ST_FINISH: begin
                if (!last_reg) begin
                    count_next = count_reg + CNT_W'(store_reg);
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_min_next   = min_reg;
                    m_ovf_next   = ovf_reg;
                    count_next   = '0;
                    min_next     = START_MIN;
                    ovf_next     = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            min_reg       <= START_MIN;
            ovf_reg       <= 1'b0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            min_reg       <= min_next;
            ovf_reg       <= ovf_next;
            cmp_valid_reg <= rd_en;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        word_reg   <= word_next;
        last_reg   <= last_next;
        store_reg  <= store_next;
        m_min_reg  <= m_min_next;
        m_ovf_reg  <= m_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_ovf_reg, m_min_reg};

    // The scan only ever reads entries written earlier in the current set.
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (rd_idx_reg < count_reg))
        else $error("scan address beyond stored words");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_COUNT)
        else $error("word count exceeds capacity");

    a_min_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        min_reg <= START_MIN)
        else $error("running minimum above start value");

    // A result leaves the closing step with the set's state cleared.
    a_clear_after_result: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FINISH) && last_reg && out_free)
            |=> ((count_reg == '0) && (min_reg == START_MIN) && !ovf_reg && m_valid_reg))
        else $error("set state not cleared after result");

endmodule

// ----- sv/mphd_store.sv -----
module mphd_store (
    input  logic                                aclk,
    input  mphd_pkg::wr_req_t                   wr,
    input  logic                                rd_en,
    input  logic [mphd_pkg::ADDR_W-1:0]         rd_addr,
    output logic [mphd_pkg::DATA_W-1:0]         rd_data
);
    import mphd_pkg::*;

    logic [DATA_W-1:0] mem [MAX_WORDS];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
